FILE: hw/rtl/htw_pkg.sv
// shared types and constants for the hashed timer wheel
// no dependencies

package htw_pkg;

    localparam int FUNC_W    = 2;
    localparam int ID_W      = 4;
    localparam int DELAY_W   = 24;
    localparam int TLEN_W    = 16;
    localparam int ROT_W     = 14;
    localparam logic [ROT_W-1:0] ROT_MAX = 14'h3fff;

    localparam int WHEEL_SLOTS = 1024;
    localparam int TIMER_COUNT = 16;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_ADJUST = 2'd2,
        FUNC_TICK   = 2'd3
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [ID_W-1:0]     timer_id;
        logic [DELAY_W-1:0]  timeout;
        logic                periodic;
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ARM,
        ST_SCAN,
        ST_REDIV,
        ST_REARM,
        ST_EMIT
    } t_state;

endpackage

FILE: hw/rtl/hashed_timer_wheel.sv
// hashed timer wheel top level: config register, request queue, back part
// add/adjust: 24-step serial divide in the back part, then arm; remove clears
// the armed bit; tick: 16-entry scan, an emit state per expiry, a re-divide per
// periodic re-arm, plus output stalls; one item in the back part at a time
// synchronous active-low reset clears armed bits, current slot; tick_length = 1

module hashed_timer_wheel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // func, timer_id, timeout, periodic
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // fired_id
    output logic        m_axis_tlast
);

    logic [htw_pkg::TLEN_W-1:0] r_tick_length;
    htw_pkg::t_req              w_in;
    htw_pkg::t_req              w_q;
    logic                       w_qv;
    logic                       w_qr;
    logic [htw_pkg::ID_W-1:0]   w_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_length <= htw_pkg::TLEN_W'(1);
        end else if (i_cfg_we) begin
            r_tick_length <= i_cfg_wdata;
        end
    end

    assign w_in.func     = htw_pkg::t_func'(s_axis_tdata[1:0]);
    assign w_in.timer_id = s_axis_tdata[5:2];
    assign w_in.timeout  = s_axis_tdata[29:6];
    assign w_in.periodic = s_axis_tdata[30];

    htw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (w_in),
        .o_valid (w_qv),
        .i_ready (w_qr),
        .o_req   (w_q)
    );

    htw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_length (r_tick_length),
        .i_valid       (w_qv),
        .o_ready       (w_qr),
        .i_req         (w_q),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_fired_id    (w_id),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, w_id};

endmodule

FILE: hw/rtl/htw_front.sv
// front part: accepts request items and holds them in a two-entry queue
// depends on htw_pkg

module htw_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  htw_pkg::t_req    i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output htw_pkg::t_req    o_req
);

    htw_pkg::t_req r_q [2];
    logic          r_rd;
    logic          r_wr;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_req;
        end
    end

    property p_cnt_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3;
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("queue count out of range");

    property p_head_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_req));
    endproperty
    a_head_hold: assert property (p_head_hold) else $error("queue head changed while stalled");

endmodule

FILE: hw/rtl/htw_div.sv
// restoring divider, one quotient bit per cycle
// depends on htw_pkg

module htw_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [htw_pkg::DELAY_W-1:0] i_num,
    input  logic [htw_pkg::TLEN_W-1:0]  i_den,
    output logic                        o_done,
    output logic [htw_pkg::DELAY_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(htw_pkg::DELAY_W + 1);

    logic [htw_pkg::DELAY_W-1:0] r_quo;
    logic [htw_pkg::TLEN_W:0]    r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic [htw_pkg::TLEN_W:0]    w_sh;
    logic [htw_pkg::TLEN_W:0]    w_den;

    assign w_den  = {1'b0, i_den};
    assign w_sh   = {r_rem[htw_pkg::TLEN_W-1:0], r_quo[htw_pkg::DELAY_W-1]};
    assign o_quo  = r_quo;
    assign o_done = r_busy && (r_cnt == CNT_W'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(htw_pkg::DELAY_W);
        end else if (r_busy) begin
            if (r_cnt == CNT_W'(0)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_busy && r_cnt != CNT_W'(0)) begin
            if (w_sh >= w_den) begin
                r_rem <= w_sh - w_den;
                r_quo <= {r_quo[htw_pkg::DELAY_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_quo <= {r_quo[htw_pkg::DELAY_W-2:0], 1'b0};
            end
        end
    end

endmodule

FILE: hw/rtl/htw_back.sv
// back part: entry table, arming with divider, tick scan and result register
// depends on htw_pkg and htw_div

module htw_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [htw_pkg::TLEN_W-1:0] i_tick_length,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  htw_pkg::t_req              i_req,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [htw_pkg::ID_W-1:0]   o_fired_id,
    output logic                       o_last
);

    localparam int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS;
    localparam int TIMER_COUNT = htw_pkg::TIMER_COUNT;
    localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int IDX_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W  = $clog2(TIMER_COUNT + 1);
    localparam int D      = htw_pkg::DELAY_W;

    htw_pkg::t_state r_state, n_state;

    logic [TIMER_COUNT-1:0]      r_armed;
    logic [SLOT_W-1:0]           r_slot [TIMER_COUNT];
    logic [htw_pkg::ROT_W-1:0]   r_rot  [TIMER_COUNT];
    logic [D-1:0]                r_dly  [TIMER_COUNT];
    logic [TIMER_COUNT-1:0]      r_rep;
    logic [SLOT_W-1:0]           r_cur;
    logic [CNT_W-1:0]            r_k;
    htw_pkg::t_req               r_req;
    logic                        r_have;
    logic                        r_dgo;
    logic [IDX_W-1:0]            r_pid;
    logic                        r_ovalid;
    logic [htw_pkg::ID_W-1:0]    r_oid;
    logic                        r_olast;

    logic [htw_pkg::TLEN_W-1:0]  w_len;
    logic                        w_dstart;
    logic [D-1:0]                w_dnum;
    logic                        w_ddone;
    logic [D-1:0]                w_quo;
    logic [D-1:0]                w_ticks;
    logic [D-1:0]                w_rot_full;
    logic [htw_pkg::ROT_W-1:0]   w_rot;
    logic [SLOT_W-1:0]           w_slot;
    logic [IDX_W-1:0]            w_k;
    logic                        w_hit;
    logic                        w_fire;
    logic                        w_kend;
    logic                        w_ok_id;
    logic                        w_accept;
    logic                        w_emit;
    logic [IDX_W-1:0]            w_arm_k;

    assign w_len   = (i_tick_length == '0) ? htw_pkg::TLEN_W'(1) : i_tick_length;
    assign w_k     = r_k[IDX_W-1:0];
    assign w_kend  = (r_k == CNT_W'(TIMER_COUNT));
    assign w_hit   = !w_kend && r_armed[w_k] && (r_slot[w_k] == r_cur);
    assign w_fire  = w_hit && (r_rot[w_k] == '0);
    assign w_ok_id = ({1'b0, i_req.timer_id} < 5'(TIMER_COUNT));
    assign w_emit  = !r_ovalid || i_ready;

    assign w_ticks    = (w_quo == '0) ? D'(1) : w_quo;
    assign w_rot_full = D'(w_ticks / WHEEL_SLOTS);
    assign w_rot      = (w_rot_full > D'(htw_pkg::ROT_MAX)) ? htw_pkg::ROT_MAX
                                                           : w_rot_full[htw_pkg::ROT_W-1:0];
    assign w_slot     = SLOT_W'((D'(r_cur) + w_ticks) % WHEEL_SLOTS);
    assign w_arm_k    = (r_state == htw_pkg::ST_ARM) ? r_req.timer_id[IDX_W-1:0] : w_k;

    assign o_ready    = (r_state == htw_pkg::ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign o_valid    = r_ovalid;
    assign o_fired_id = r_oid;
    assign o_last     = r_olast;

    always_comb begin
        w_dstart = 1'b0;
        w_dnum   = r_req.timeout;
        unique case (r_state)
            htw_pkg::ST_DIV: begin
                w_dstart = !r_dgo;
            end
            htw_pkg::ST_REDIV: begin
                w_dstart = !r_dgo;
                w_dnum   = r_dly[w_k];
            end
            default: begin
                w_dstart = 1'b0;
            end
        endcase
    end

    htw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_len),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            htw_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.func == htw_pkg::FUNC_TICK) begin
                        n_state = htw_pkg::ST_SCAN;
                    end else if (w_ok_id && i_req.func != htw_pkg::FUNC_REMOVE) begin
                        n_state = htw_pkg::ST_DIV;
                    end
                end
            end
            htw_pkg::ST_DIV: begin
                if (w_ddone) begin
                    n_state = htw_pkg::ST_ARM;
                end
            end
            htw_pkg::ST_ARM: begin
                n_state = htw_pkg::ST_IDLE;
            end
            htw_pkg::ST_SCAN: begin
                if (w_kend) begin
                    n_state = r_have ? htw_pkg::ST_EMIT : htw_pkg::ST_IDLE;
                end else if (w_fire) begin
                    if (r_have) begin
                        n_state = htw_pkg::ST_EMIT;
                    end else if (r_rep[w_k]) begin
                        n_state = htw_pkg::ST_REDIV;
                    end
                end
            end
            htw_pkg::ST_EMIT: begin
                if (w_emit) begin
                    if (w_kend) begin
                        n_state = htw_pkg::ST_IDLE;
                    end else if (r_rep[w_k]) begin
                        n_state = htw_pkg::ST_REDIV;
                    end else begin
                        n_state = htw_pkg::ST_SCAN;
                    end
                end
            end
            htw_pkg::ST_REDIV: begin
                if (w_ddone) begin
                    n_state = htw_pkg::ST_REARM;
                end
            end
            htw_pkg::ST_REARM: begin
                n_state = htw_pkg::ST_SCAN;
            end
            default: begin
                n_state = htw_pkg::ST_IDLE;
            end
        endcase
    end

    // scan: a fire at k is held as pending; the held one is emitted when the next
    // fire or the scan end shows whether it was the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= htw_pkg::ST_IDLE;
            r_armed  <= '0;
            r_cur    <= '0;
            r_k      <= '0;
            r_have   <= 1'b0;
            r_dgo    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == htw_pkg::ST_EMIT && w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                htw_pkg::ST_IDLE: begin
                    r_k    <= '0;
                    r_have <= 1'b0;
                    if (w_accept && w_ok_id && i_req.func == htw_pkg::FUNC_REMOVE) begin
                        r_armed[i_req.timer_id[IDX_W-1:0]] <= 1'b0;
                    end
                end
                htw_pkg::ST_DIV: begin
                    r_dgo <= !w_ddone;
                end
                htw_pkg::ST_ARM: begin
                    r_have <= 1'b0;
                    r_armed[w_arm_k] <= 1'b1;
                end
                htw_pkg::ST_SCAN: begin
                    if (w_kend) begin
                        if (!r_have) begin
                            r_cur <= SLOT_W'((D'(r_cur) + D'(1)) % WHEEL_SLOTS);
                        end
                    end else if (w_hit && !w_fire) begin
                        r_k <= r_k + CNT_W'(1);
                    end else if (w_fire) begin
                        if (!r_have) begin
                            r_have <= 1'b1;
                            r_pid  <= w_k;
                            if (!r_rep[w_k]) begin
                                r_armed[w_k] <= 1'b0;
                                r_k <= r_k + CNT_W'(1);
                            end
                        end
                    end else begin
                        r_k <= r_k + CNT_W'(1);
                    end
                end
                htw_pkg::ST_EMIT: begin
                    if (w_emit) begin
                        r_oid   <= htw_pkg::ID_W'(r_pid);
                        r_olast <= w_kend;
                        r_have  <= !w_kend;
                        if (w_kend) begin
                            r_cur <= SLOT_W'((D'(r_cur) + D'(1)) % WHEEL_SLOTS);
                        end else begin
                            r_pid <= w_k;
                            if (!r_rep[w_k]) begin
                                r_armed[w_k] <= 1'b0;
                                r_k <= r_k + CNT_W'(1);
                            end
                        end
                    end
                end
                htw_pkg::ST_REDIV: begin
                    r_dgo <= !w_ddone;
                end
                htw_pkg::ST_REARM: begin
                    r_k <= r_k + CNT_W'(1);
                end
                default: begin
                    r_have <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == htw_pkg::ST_IDLE && w_accept) begin
            r_req <= i_req;
            if (i_req.func != htw_pkg::FUNC_TICK && i_req.func != htw_pkg::FUNC_REMOVE
                && w_ok_id) begin
                r_rep[i_req.timer_id[IDX_W-1:0]] <= i_req.periodic;
                r_dly[i_req.timer_id[IDX_W-1:0]] <= i_req.timeout;
            end
        end
        if (r_state == htw_pkg::ST_SCAN && w_hit && !w_fire) begin
            r_rot[w_k] <= r_rot[w_k] - htw_pkg::ROT_W'(1);
        end
        if (r_state == htw_pkg::ST_ARM) begin
            r_slot[w_arm_k] <= w_slot;
            r_rot[w_arm_k]  <= w_rot;
        end
        if (r_state == htw_pkg::ST_REARM) begin
            r_slot[w_k] <= w_slot;
            if (w_slot == r_cur && w_rot != '0) begin
                r_rot[w_k] <= w_rot - htw_pkg::ROT_W'(1);
            end else begin
                r_rot[w_k] <= w_rot;
            end
        end
    end

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> (r_ovalid && $stable(r_oid) && $stable(r_olast));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

    property p_idle_no_pending;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htw_pkg::ST_IDLE) |-> (r_k <= CNT_W'(TIMER_COUNT));
    endproperty
    a_idle_no_pending: assert property (p_idle_no_pending) else $error("scan index overran");

    property p_emit_pending;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htw_pkg::ST_EMIT) |-> r_have;
    endproperty
    a_emit_pending: assert property (p_emit_pending) else $error("emit with no held timer");

endmodule
